// ===== src/event_flag_group_engine_unit_assert.svh =====
// assertion macros shared by the flag group engine
`ifndef EVENT_FLAG_GROUP_ENGINE_UNIT_ASSERT_SVH
`define EVENT_FLAG_GROUP_ENGINE_UNIT_ASSERT_SVH

// a condition that must imply a consequence in the same cycle
`define EFG_ASSERT_IMP(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");

// a condition that must imply a consequence in the next cycle
`define EFG_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");

`endif

// ===== src/efg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efg_pkg
// codes and types shared by the event flag group engine
// ----------------------------------------------------------------------------
package efg_pkg;

  localparam logic [2:0] MODE_CREATE = 3'd0;
  localparam logic [2:0] MODE_DELETE = 3'd1;
  localparam logic [2:0] MODE_SET    = 3'd2;
  localparam logic [2:0] MODE_CLEAR  = 3'd3;
  localparam logic [2:0] MODE_GET    = 3'd4;
  localparam logic [2:0] MODE_WAIT   = 3'd5;
  localparam logic [2:0] MODE_CANCEL = 3'd6;
  localparam logic [2:0] MODE_UNUSED = 3'd7;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD      = 3'd1;
  localparam logic [2:0] ST_TIMEOUT  = 3'd2;
  localparam logic [2:0] ST_BLOCKED  = 3'd3;
  localparam logic [2:0] ST_NO_EXIST = 3'd4;
  localparam logic [2:0] ST_FULL     = 3'd5;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_READ  = 6'b000010,
    S_EXEC  = 6'b000100,
    S_WREQ  = 6'b001000,
    S_WALK  = 6'b010000,
    S_FIN   = 6'b100000
  } state_t;

endpackage

// ===== src/efg_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efg_ram
// generic ram with one write port and one read port, registered read
// ----------------------------------------------------------------------------
module efg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== src/event_flag_group_engine_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// event_flag_group_engine_unit
// pool of event flag groups with a per-task waiter table
// ----------------------------------------------------------------------------
// usage: drive mode, group, mask, match_any, clear_on_match, no_wait,
// may_block and task_req with start high while busy is low; that edge takes
// the beat. busy drops in the cycle the last result is shown.
// results come out on status, word, group_out, is_wake, woken_task and
// last, marked by valid for exactly one cycle; wake results of set and
// delete come first, one per cycle save for waiters that do not match,
// the request's own result last. create, get, clear, cancel and any bad
// group end in S_EXEC, wait goes on to S_WREQ; set and delete walk each
// queued waiter in S_WALK and end in S_FIN. the next beat can be taken
// while the last result is shown. the flag words sit in a ram with
// registered read, so each request spends the S_READ state reading its
// group word.
// reset clears all groups and waiters at once through live and valid bits;
// the word ram needs no clearing since create writes it first.
// the receiver cannot stall: each result is taken in the cycle shown.
// ----------------------------------------------------------------------------
`include "event_flag_group_engine_unit_assert.svh"

module event_flag_group_engine_unit #(
  parameter int GROUPS    = 32,
  parameter int TASKS     = 8,
  parameter int FLAG_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  mode,
  input  logic [4:0]  group,
  input  logic [31:0] mask,
  input  logic        match_any,
  input  logic        clear_on_match,
  input  logic        no_wait,
  input  logic        may_block,
  input  logic [2:0]  task_req,
  output logic        valid,
  output logic [2:0]  status,
  output logic [31:0] word,
  output logic [4:0]  group_out,
  output logic        is_wake,
  output logic [2:0]  woken_task,
  output logic        last
);
  localparam int GW = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int TW = (TASKS > 1) ? $clog2(TASKS) : 1;
  localparam int CW = $clog2(TASKS + 1);

  efg_pkg::state_t state;

  // request latches
  logic [2:0]           r_mode;
  logic [4:0]           r_group;
  logic [FLAG_BITS-1:0] r_mask;
  logic                 r_any, r_clr, r_poll, r_block;
  logic [2:0]           r_task;
  logic [TW-1:0]        rt;

  logic [GROUPS-1:0]    live;
  logic [TASKS-1:0]     wvalid;
  logic [GW-1:0]        wgroup [TASKS];
  logic [FLAG_BITS-1:0] wmask [TASKS];
  logic [TASKS-1:0]     wany, wclr;
  logic [TW-1:0]        order [TASKS];
  logic [CW-1:0]        queued;

  logic [CW-1:0]        idx;
  logic [FLAG_BITS-1:0] cur;
  logic                 gok;

  // word ram
  logic                 ram_we;
  logic [GW-1:0]        ram_waddr, ram_raddr;
  logic [FLAG_BITS-1:0] ram_wdata, ram_rdata;

  efg_ram #(.WIDTH(FLAG_BITS), .DEPTH(GROUPS)) u_word (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  assign busy = (state != efg_pkg::S_IDLE);
  assign ram_raddr = r_group[GW-1:0];
  assign rt = TW'(r_task);

  logic [FLAG_BITS-1:0] mask_n;
  assign mask_n = FLAG_BITS'(mask);

  // lowest free group
  logic          free_found;
  logic [GW-1:0] free_idx;
  always_comb begin
    free_found = 1'b0;
    free_idx = '0;
    for (int i = GROUPS - 1; i >= 0; i--) begin
      if (!live[i]) begin
        free_found = 1'b1;
        free_idx = GW'(i);
      end
    end
  end

  // flag match test, then position of task in arrival list
  function automatic logic match_fn(input logic [FLAG_BITS-1:0] w, m,
                                    input logic a);
    match_fn = a ? ((w & m) != '0) : ((w & m) == m);
  endfunction

  logic          tpos_found;
  logic [CW-1:0] tpos;
  always_comb begin
    tpos_found = 1'b0;
    tpos = '0;
    for (int i = TASKS - 1; i >= 0; i--) begin
      if (CW'(i) < queued && 32'(order[i]) == 32'(r_task)) begin
        tpos_found = 1'b1;
        tpos = CW'(i);
      end
    end
  end

  // walk slot under inspection
  logic [TW-1:0] wt;
  logic          w_hit;
  assign wt = order[idx[TW-1:0]];
  always_comb begin
    w_hit = (32'(wgroup[wt]) == 32'(r_group));
    if (r_mode == efg_pkg::MODE_SET) begin
      w_hit = w_hit && match_fn(cur, wmask[wt], wany[wt]);
    end
  end

  logic task_ok;
  assign task_ok = 32'(r_task) < TASKS;

  always_ff @(posedge clk) begin
    valid <= 1'b0;
    ram_we <= 1'b0;
    if (rst) begin
      state <= efg_pkg::S_IDLE;
      live <= '0;
      wvalid <= '0;
      queued <= '0;
    end else begin
      unique case (state)
        efg_pkg::S_IDLE: begin
          if (start) begin
            r_mode <= mode; r_group <= group; r_mask <= mask_n;
            r_any <= match_any; r_clr <= clear_on_match;
            r_poll <= no_wait; r_block <= may_block; r_task <= task_req;
            if (mode != efg_pkg::MODE_UNUSED) state <= efg_pkg::S_READ;
          end
        end
        efg_pkg::S_READ: begin
          gok <= (32'(r_group) < GROUPS) && live[r_group[GW-1:0]];
          state <= efg_pkg::S_EXEC;
        end
        efg_pkg::S_EXEC: begin
          cur <= ram_rdata;
          idx <= '0;
          status <= efg_pkg::ST_OK; word <= '0; group_out <= '0;
          is_wake <= 1'b0; woken_task <= '0; last <= 1'b1;
          state <= efg_pkg::S_IDLE;
          valid <= 1'b1;
          unique case (r_mode)
            efg_pkg::MODE_CREATE: begin
              if (free_found) begin
                live[free_idx] <= 1'b1;
                ram_we <= 1'b1; ram_waddr <= free_idx; ram_wdata <= r_mask;
                word <= 32'(r_mask); group_out <= 5'(free_idx);
              end else status <= efg_pkg::ST_FULL;
            end
            efg_pkg::MODE_DELETE, efg_pkg::MODE_SET: begin
              if (!gok) status <= efg_pkg::ST_BAD;
              else begin
                valid <= 1'b0;
                if (r_mode == efg_pkg::MODE_SET) cur <= ram_rdata | r_mask;
                state <= efg_pkg::S_WALK;
              end
            end
            efg_pkg::MODE_CLEAR: begin
              if (!gok) status <= efg_pkg::ST_BAD;
              else begin
                ram_we <= 1'b1; ram_waddr <= r_group[GW-1:0];
                ram_wdata <= ram_rdata & ~r_mask;
                word <= 32'(ram_rdata & ~r_mask);
              end
            end
            efg_pkg::MODE_GET: begin
              if (!gok) status <= efg_pkg::ST_BAD;
              else word <= 32'(ram_rdata);
            end
            efg_pkg::MODE_WAIT: begin
              woken_task <= r_task;
              if (!gok || !task_ok) status <= efg_pkg::ST_BAD;
              else begin
                valid <= 1'b0;
                state <= efg_pkg::S_WREQ;
                // drop an old wait first
                if (wvalid[rt] && tpos_found) begin
                  for (int j = 0; j < TASKS - 1; j++)
                    if (CW'(j) >= tpos) order[j] <= order[j + 1];
                  queued <= queued - 1'b1;
                end
                wvalid[rt] <= 1'b0;
              end
            end
            efg_pkg::MODE_CANCEL: begin
              woken_task <= r_task;
              if (task_ok && wvalid[rt]) begin
                if (tpos_found) begin
                  for (int j = 0; j < TASKS - 1; j++)
                    if (CW'(j) >= tpos) order[j] <= order[j + 1];
                  queued <= queued - 1'b1;
                end
                wvalid[rt] <= 1'b0;
              end else status <= efg_pkg::ST_BAD;
            end
            default: valid <= 1'b0;
          endcase
        end
        efg_pkg::S_WREQ: begin
          valid <= 1'b1;
          state <= efg_pkg::S_IDLE;
          if (match_fn(cur, r_mask, r_any) || r_poll) begin
            word <= 32'(cur);
            if (r_clr) begin
              ram_we <= 1'b1; ram_waddr <= r_group[GW-1:0];
              ram_wdata <= cur & ~r_mask;
            end
          end else if (!r_block) status <= efg_pkg::ST_TIMEOUT;
          else begin
            wvalid[rt] <= 1'b1;
            wgroup[rt] <= r_group[GW-1:0];
            wmask[rt] <= r_mask;
            wany[rt] <= r_any;
            wclr[rt] <= r_clr;
            if (32'(queued) < TASKS) begin
              order[queued[TW-1:0]] <= rt;
              queued <= queued + 1'b1;
            end
            status <= efg_pkg::ST_BLOCKED;
          end
        end
        efg_pkg::S_WALK: begin
          if (idx < queued) begin
            if (w_hit) begin
              valid <= 1'b1; last <= 1'b0; is_wake <= 1'b1;
              woken_task <= 3'(wt);
              if (r_mode == efg_pkg::MODE_SET) begin
                word <= 32'(cur);
                if (wclr[wt]) cur <= cur & ~wmask[wt];
              end else begin
                status <= efg_pkg::ST_NO_EXIST; word <= '0;
              end
              for (int j = 0; j < TASKS - 1; j++)
                if (CW'(j) >= idx) order[j] <= order[j + 1];
              queued <= queued - 1'b1;
              wvalid[wt] <= 1'b0;
            end else idx <= idx + 1'b1;
          end else state <= efg_pkg::S_FIN;
        end
        efg_pkg::S_FIN: begin
          valid <= 1'b1; last <= 1'b1; is_wake <= 1'b0;
          woken_task <= '0; status <= efg_pkg::ST_OK;
          ram_we <= 1'b1; ram_waddr <= r_group[GW-1:0];
          if (r_mode == efg_pkg::MODE_SET) begin
            word <= 32'(cur); ram_wdata <= cur;
          end else begin
            word <= '0; ram_wdata <= '0;
            live[r_group[GW-1:0]] <= 1'b0;
          end
          state <= efg_pkg::S_IDLE;
        end
        default: state <= efg_pkg::S_IDLE;
      endcase
    end
  end

  `EFG_ASSERT_IMP(a_queue_bound, clk, rst, 1'b1, queued <= CW'(TASKS))
  `EFG_ASSERT_IMP(a_valid_busy_last, clk, rst, valid && last, !busy)
  `EFG_ASSERT_NEXT(a_start_busy, clk, rst, start && !busy && mode != efg_pkg::MODE_UNUSED, busy)
  `EFG_ASSERT_IMP(a_count_valid, clk, rst, 1'b1, $countones(wvalid) == 32'(queued))
endmodule
